// ----- rtl/hypercube_diagnosis_tester_select_defines.svh -----
// ----------------------------------------------------------------------------
// Hypercube diagnosis tester select - assertion macros
// Concurrent assertion wrappers; defining NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef HYPERCUBE_DIAGNOSIS_TESTER_SELECT_DEFINES_SVH
`define HYPERCUBE_DIAGNOSIS_TESTER_SELECT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked assertion with synchronous reset disable
`define HDTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked assertion that also holds during reset
`define HDTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HDTS_ASSERT(lbl, clk, rst, prop, msg)
`define HDTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/hdts_pkg.sv -----
// ----------------------------------------------------------------------------
// Hypercube diagnosis tester select - package
// Shared constants, register indexes, opcodes and controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package hdts_pkg;

   // default sizing
   localparam int NODES_DEFAULT       = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // register indexes on the config port
   localparam logic REG_NODE_ID = 1'b0;
   localparam logic REG_DIMS    = 1'b1;

   // register reset values
   localparam logic [3:0] NODE_ID_RESET = 4'd0;
   localparam logic [2:0] DIMS_RESET    = 3'd4;

   // input opcodes
   localparam logic OP_MERGE = 1'b0;
   localparam logic OP_LIST  = 1'b1;

   // controller states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MREAD  = 6'b000010,
      ST_MCHECK = 6'b000100,
      ST_LREAD  = 6'b001000,
      ST_LCHECK = 6'b010000,
      ST_LFLUSH = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/hypercube_diagnosis_tester_select.sv -----
// ----------------------------------------------------------------------------
// Hypercube diagnosis tester select - top level
// Per-node diagnosis engine: merges gossiped event counters and computes the
// list of nodes this engine must test in a hypercube of 2^dims nodes.
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_ready  opcode, entry_index, entry_value
//   rsp_*     out        rsp_valid/rsp_ready  novelty, tested_node, list_empty,
//                                             last
//   csr       in/out     APB psel/penable     node_id (0x0), dims (0x4)
//
// One item at a time; req_ready is high while the controller is idle, even
// when a result still waits in the output register.
// Merge steps: accept, counter read, compare and write back.
// List: each counter probe is a RAM read then a check; with d levels the scan
// makes between d*2^d and 2^d*(2^d-1) probes, plus accept and final flush.
// The counter RAM port is used once per probe. Reset needs no clearing pass:
// per-entry valid bits give unwritten counters their reset value.
// A full output register stalls the controller where it must push a result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hypercube_diagnosis_tester_select_defines.svh"

module hypercube_diagnosis_tester_select #(
   parameter int NODES       = hdts_pkg::NODES_DEFAULT,
   parameter int COUNT_WIDTH = hdts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input items
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_opcode,
   input  wire logic [3:0]         req_entry_index,
   input  wire logic signed [15:0] req_entry_value,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_novelty,
   output logic [3:0]              rsp_tested_node,
   output logic                    rsp_list_empty,
   output logic                    rsp_last,
   // configuration port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int AW   = $clog2(NODES);
   localparam int DMAX = ((1 << AW) > NODES) ? AW - 1 : AW;
   localparam int EW   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam logic [2:0] DMAX_L = 3'(DMAX);
   localparam logic signed [EW-1:0] CMAX = EW'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] CMIN = ~CMAX;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [3:0] node_id_ff;
   logic [2:0] dims_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= hdts_pkg::NODE_ID_RESET;
         dims_ff    <= hdts_pkg::DIMS_RESET;
      end else if (csr_write) begin
         if (paddr[2] == hdts_pkg::REG_NODE_ID) begin
            node_id_ff <= pwdata[3:0];
         end else begin
            dims_ff <= pwdata[2:0];
         end
      end
   end

   // register readback
   always_comb begin
      prdata = '0;
      if (paddr[2] == hdts_pkg::REG_NODE_ID) begin
         prdata[3:0] = node_id_ff;
      end else begin
         prdata[2:0] = dims_ff;
      end
   end

   // ------------------------------------------------------------------------
   // counter store: RAM plus per-entry valid bits
   // ------------------------------------------------------------------------
   logic                   ram_we;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr;
   logic [COUNT_WIDTH-1:0] ram_rdata;
   logic [NODES-1:0]       valid_ff;
   logic [NODES-1:0]       valid_in;
   logic                   rd_valid_ff;
   logic                   rd_zero_ff;
   logic signed [COUNT_WIDTH-1:0] cur_count;
   logic                   fault_free;

   // merge operands
   logic [AW-1:0]                 mrg_idx_ff,     mrg_idx_in;
   logic                          mrg_inrange_ff, mrg_inrange_in;
   logic signed [COUNT_WIDTH-1:0] mrg_val_ff,     mrg_val_in;

   hdts_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NODES)
   ) u_counts (
      .clock (clock),
      .we    (ram_we),
      .waddr (mrg_idx_ff),
      .wdata (mrg_val_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // track whether the entry being read was ever written
   always_ff @(posedge clock) begin
      if (ram_re) begin
         rd_valid_ff <= valid_ff[ram_raddr];
         rd_zero_ff  <= (ram_raddr == '0);
      end
   end

   // unwritten entries read as reset value: 0 for entry 0, else all ones
   always_comb begin
      if (rd_valid_ff) begin
         cur_count = ram_rdata;
      end else if (rd_zero_ff) begin
         cur_count = '0;
      end else begin
         cur_count = '1;
      end
   end

   assign fault_free = !cur_count[0] || (&cur_count);

   // ------------------------------------------------------------------------
   // merge value: sign-extend then saturate to counter width
   // ------------------------------------------------------------------------
   logic signed [EW-1:0] ext_val;
   logic signed [EW-1:0] sat_val;

   assign ext_val = EW'(req_entry_value);

   always_comb begin
      if (ext_val > CMAX) begin
         sat_val = CMAX;
      end else if (ext_val < CMIN) begin
         sat_val = CMIN;
      end else begin
         sat_val = ext_val;
      end
   end

   // ------------------------------------------------------------------------
   // scan geometry
   // ------------------------------------------------------------------------
   logic [2:0]    d_eff;
   logic [AW:0]   n_full;
   logic [AW:0]   n_less;
   logic [AW-1:0] i_mask;
   logic [AW-1:0] scan_i_ff, scan_i_in;
   logic [2:0]    scan_s_ff, scan_s_in;
   logic [AW-1:0] scan_k_ff, scan_k_in;
   logic [AW-1:0] cs_bit;
   logic [AW-1:0] cs_mask;
   logic [AW-1:0] ik_sum;
   logic [AW-1:0] probe_addr;
   logic [AW-1:0] probe_ff,  probe_in;
   logic          node_match;
   logic          k_last;
   logic          s_last;
   logic          i_last;

   assign d_eff  = (dims_ff > DMAX_L) ? DMAX_L : dims_ff;
   assign n_full = (AW + 1)'(1) << d_eff;
   assign n_less = n_full - (AW + 1)'(1);
   assign i_mask = n_less[AW-1:0];

   // cluster c(i,s): flip bit s, keep higher bits, rotate over lower bits
   assign cs_bit     = AW'(1) << scan_s_ff;
   assign cs_mask    = cs_bit - AW'(1);
   assign ik_sum     = scan_i_ff + scan_k_ff;
   assign probe_addr = ((scan_i_ff ^ cs_bit) & ~cs_mask) | (ik_sum & cs_mask);

   assign node_match = (32'(probe_ff) == 32'(node_id_ff));
   assign k_last     = (scan_k_ff == cs_mask);
   assign s_last     = (scan_s_ff == (d_eff - 3'd1));
   assign i_last     = (scan_i_ff == i_mask);

   // ------------------------------------------------------------------------
   // controller
   // ------------------------------------------------------------------------
   hdts_pkg::state_type state_ff, state_in;

   logic       pend_valid_ff, pend_valid_in;
   logic [3:0] pend_node_ff,  pend_node_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_nov_ff,   out_nov_in;
   logic [3:0] out_node_ff,  out_node_in;
   logic       out_empty_ff, out_empty_in;
   logic       out_last_ff,  out_last_in;
   logic       out_free;
   logic       merge_upd;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == hdts_pkg::ST_IDLE);
   assign merge_upd = mrg_inrange_ff && (mrg_val_ff > cur_count);

   always_comb begin
      state_in       = state_ff;
      mrg_idx_in     = mrg_idx_ff;
      mrg_inrange_in = mrg_inrange_ff;
      mrg_val_in     = mrg_val_ff;
      scan_i_in      = scan_i_ff;
      scan_s_in      = scan_s_ff;
      scan_k_in      = scan_k_ff;
      probe_in       = probe_ff;
      pend_valid_in  = pend_valid_ff;
      pend_node_in   = pend_node_ff;
      valid_in       = valid_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = probe_addr;
      // output register drains on its own handshake
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_nov_in     = out_nov_ff;
      out_node_in    = out_node_ff;
      out_empty_in   = out_empty_ff;
      out_last_in    = out_last_ff;

      case (state_ff)
         hdts_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == hdts_pkg::OP_MERGE) begin
                  mrg_idx_in     = AW'(req_entry_index);
                  mrg_inrange_in = (32'(req_entry_index) < NODES);
                  mrg_val_in     = COUNT_WIDTH'(sat_val);
                  state_in       = hdts_pkg::ST_MREAD;
               end else begin
                  scan_i_in     = '0;
                  scan_s_in     = '0;
                  scan_k_in     = '0;
                  pend_valid_in = 1'b0;
                  state_in      = (d_eff == 3'd0) ? hdts_pkg::ST_LFLUSH
                                                  : hdts_pkg::ST_LREAD;
               end
            end
         end

         // merge: read current entry
         hdts_pkg::ST_MREAD: begin
            ram_re    = 1'b1;
            ram_raddr = mrg_idx_ff;
            state_in  = hdts_pkg::ST_MCHECK;
         end

         // merge: keep the larger value, report the result
         hdts_pkg::ST_MCHECK: begin
            if (out_free) begin
               ram_we = merge_upd;
               if (merge_upd) begin
                  valid_in[mrg_idx_ff] = 1'b1;
               end
               out_valid_in = 1'b1;
               out_nov_in   = merge_upd && (mrg_val_ff != '0);
               out_node_in  = '0;
               out_empty_in = 1'b0;
               out_last_in  = 1'b1;
               state_in     = hdts_pkg::ST_IDLE;
            end
         end

         // list: fetch one cluster member
         hdts_pkg::ST_LREAD: begin
            ram_re    = 1'b1;
            ram_raddr = probe_addr;
            probe_in  = probe_addr;
            state_in  = hdts_pkg::ST_LCHECK;
         end

         // list: first fault-free member decides the tester of node i
         hdts_pkg::ST_LCHECK: begin
            if (!(fault_free && node_match && pend_valid_ff && !out_free)) begin
               if (fault_free && node_match) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_nov_in   = 1'b0;
                     out_node_in  = pend_node_ff;
                     out_empty_in = 1'b0;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_node_in  = 4'(scan_i_ff);
               end
               state_in = hdts_pkg::ST_LREAD;
               if (!fault_free && !k_last) begin
                  scan_k_in = scan_k_ff + AW'(1);
               end else begin
                  scan_k_in = '0;
                  if (!s_last) begin
                     scan_s_in = scan_s_ff + 3'd1;
                  end else begin
                     scan_s_in = '0;
                     if (i_last) begin
                        state_in = hdts_pkg::ST_LFLUSH;
                     end else begin
                        scan_i_in = scan_i_ff + AW'(1);
                     end
                  end
               end
            end
         end

         // list: final result marked last, or the empty-list result
         hdts_pkg::ST_LFLUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_nov_in   = 1'b0;
               out_node_in  = pend_valid_ff ? pend_node_ff : 4'd0;
               out_empty_in = !pend_valid_ff;
               out_last_in  = 1'b1;
               state_in     = hdts_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = hdts_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hdts_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mrg_idx_ff     <= mrg_idx_in;
      mrg_inrange_ff <= mrg_inrange_in;
      mrg_val_ff     <= mrg_val_in;
      scan_i_ff      <= scan_i_in;
      scan_s_ff      <= scan_s_in;
      scan_k_ff      <= scan_k_in;
      probe_ff       <= probe_in;
      pend_node_ff   <= pend_node_in;
      out_nov_ff     <= out_nov_in;
      out_node_ff    <= out_node_in;
      out_empty_ff   <= out_empty_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_novelty     = out_nov_ff;
   assign rsp_tested_node = out_node_ff;
   assign rsp_list_empty  = out_empty_ff;
   assign rsp_last        = out_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `HDTS_ASSERT(a_write_in_merge, clock, reset, ram_we |-> (state_ff == hdts_pkg::ST_MCHECK && mrg_inrange_ff && out_free), "counter write outside merge check")
   `HDTS_ASSERT(a_empty_is_last, clock, reset, (rsp_valid && rsp_list_empty) |-> (rsp_last && !rsp_novelty), "empty-list item not marked last")
   `HDTS_ASSERT(a_flush_last, clock, reset, (state_ff == hdts_pkg::ST_LFLUSH && out_free) |=> (rsp_valid && rsp_last && state_ff == hdts_pkg::ST_IDLE), "list run did not end with last item")

endmodule

`default_nettype wire

// ----- rtl/hdts_ram.sv -----
// ----------------------------------------------------------------------------
// Hypercube diagnosis tester select - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hdts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire
